// ----- hw/rtl/four_level_page_walker_macros.svh -----
// ----------------------------------------------------------------------------
// four_level_page_walker assertion macros
// shorthand for clocked implication checks under asynchronous reset
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_WALKER_MACROS_SVH

// same-cycle implication
`define FPW_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/fpw_pkg.sv -----
// ----------------------------------------------------------------------------
// fpw_pkg
// shared constants, codes, types and helpers of the page walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpw_pkg;

	localparam int TABLE_FRAMES      = 64;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int FRAME_W           = $clog2(TABLE_FRAMES);
	localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
	localparam int ADDR_W            = FRAME_W + IDX_W;
	localparam int STORE_DEPTH       = TABLE_FRAMES * ENTRIES_PER_TABLE;

	localparam int ENTRY_W    = 64;
	localparam int VA_W       = 48;
	localparam int FA_W       = 52;
	localparam int PAGE_SHIFT = 12;
	localparam int PFN_W      = 40;

	localparam int BIT_PRESENT  = 0;
	localparam int BIT_WRITABLE = 1;
	localparam int BIT_USER     = 2;
	localparam int BIT_HUGE     = 7;
	localparam int BIT_NOEXEC   = 63;

	typedef enum logic [1:0] {
		REQ_WRITE     = 2'd0,
		REQ_TRANSLATE = 2'd1,
		REQ_TOGGLE    = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		STS_OK          = 2'd0,
		STS_NOT_PRESENT = 2'd1,
		STS_OUT_STORE   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SIZE_4K = 2'd0,
		SIZE_2M = 2'd1,
		SIZE_1G = 2'd2
	} size_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_WBACK,
		ST_RESP
	} state_t;

	// result of evaluating one table entry at one level
	typedef struct packed {
		logic              present;
		logic              leaf;
		size_t             size;
		logic [FA_W-1:0]   fa;
		logic              next_ok;
		logic [ADDR_W-1:0] next_addr;
	} step_t;

	// 9-bit table index of a level, level 0 is the top table
	function automatic logic [IDX_W-1:0] va_idx(input logic [VA_W-1:0] va,
		input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd0:    idx = va[47:39];
			2'd1:    idx = va[38:30];
			2'd2:    idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	// attribute inversion pattern for a toggle
	function automatic logic [ENTRY_W-1:0] flip_bits(input logic [2:0] mask);
		logic [ENTRY_W-1:0] f;
		f = '0;
		f[BIT_WRITABLE] = mask[0];
		f[BIT_NOEXEC]   = mask[1];
		f[BIT_USER]     = mask[2];
		return f;
	endfunction

endpackage

// ----- hw/rtl/fpw_ram.sv -----
// ----------------------------------------------------------------------------
// fpw_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/fpw_step.sv -----
// ----------------------------------------------------------------------------
// fpw_step
// per-level entry evaluation shared by every level of the walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpw_step (
	input  logic [fpw_pkg::ENTRY_W-1:0] entry,
	input  logic [1:0]                  lvl,
	input  logic [fpw_pkg::VA_W-1:0]    va,
	output fpw_pkg::step_t              step
);

	// compare width wide enough for the frame number and the frame count
	localparam int PFN_W_EXT = fpw_pkg::PFN_W + 1;

	logic [fpw_pkg::PFN_W-1:0] pfn;
	logic                      huge;
	logic [1:0]                lvl_next;

	assign pfn      = entry[fpw_pkg::PAGE_SHIFT +: fpw_pkg::PFN_W];
	assign huge     = entry[fpw_pkg::BIT_HUGE];
	assign lvl_next = lvl + 2'd1;

	always_comb begin
		step.present   = entry[fpw_pkg::BIT_PRESENT];
		step.leaf      = 1'b0;
		step.size      = fpw_pkg::SIZE_4K;
		step.fa        = '0;
		step.next_ok   = (PFN_W_EXT'(pfn) < PFN_W_EXT'(fpw_pkg::TABLE_FRAMES));
		step.next_addr = {pfn[fpw_pkg::FRAME_W-1:0], fpw_pkg::va_idx(va, lvl_next)};
		case (lvl)
			2'd1: begin
				// 1g leaf, both lower indices fold into the frame
				if (huge) begin
					step.leaf = 1'b1;
					step.size = fpw_pkg::SIZE_1G;
					step.fa   = {pfn | {22'd0, va[29:12]}, 12'd0};
				end
			end
			2'd2: begin
				if (huge) begin
					step.leaf = 1'b1;
					step.size = fpw_pkg::SIZE_2M;
					step.fa   = {pfn | {31'd0, va[20:12]}, 12'd0};
				end
			end
			2'd3: begin
				step.leaf = 1'b1;
				step.size = fpw_pkg::SIZE_4K;
				step.fa   = {pfn, 12'd0};
			end
			default: begin
				step.leaf = 1'b0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/four_level_page_walker.sv -----
// ----------------------------------------------------------------------------
// four_level_page_walker
// four-level page table walker over an on-chip store of table frames
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) takes one request word: a table entry
//   write, an address translate or a leaf attribute toggle
//   output channel (out_valid/out_ready) returns one result word per request:
//   status, frame address and page size
//   config channel (cfg_valid/cfg_ready) loads the root table frame; always
//   ready, write it only while no request is in flight
// sequence
//   write or unused code: the result is held in the pending result register,
//   then moved to the output register; a walk makes one store read per level
//   before its result, and a toggle adds a write-back step
//   the single store read port sets the pace; one request at a time
// reset
//   the store is swept to zero, one entry a cycle, over all 32768 entries; in_ready
//   stays low until the sweep is done, config writes are taken meanwhile
// stall
//   a result waits in the output register; a finished walk holds until the
//   register frees, and in_ready stays low until then
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "four_level_page_walker_macros.svh"

module four_level_page_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	// config channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [5:0]                   root_frame,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   req_type,
	input  logic [fpw_pkg::VA_W-1:0]     virt_addr,
	input  logic [5:0]                   frame_index,
	input  logic [8:0]                   entry_index,
	input  logic [fpw_pkg::ENTRY_W-1:0]  entry_data,
	input  logic [2:0]                   toggle_mask,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [fpw_pkg::FA_W-1:0]     frame_addr,
	output logic [1:0]                   page_size
);

	localparam int AW = fpw_pkg::ADDR_W;

	// control state
	fpw_pkg::state_t state_q, state_d;
	logic [AW-1:0]   clr_cnt_q;
	logic [1:0]      lvl_q, lvl_d;
	logic [5:0]      root_q;

	// request held during the walk
	fpw_pkg::req_t            req_q;
	logic [fpw_pkg::VA_W-1:0] va_q;
	logic [2:0]               mask_q;
	logic                     req_load;

	// store ports
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [fpw_pkg::ENTRY_W-1:0] ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [fpw_pkg::ENTRY_W-1:0] ram_rdata;
	logic [AW-1:0]               rd_addr_q;

	// toggle write-back
	logic                        wb_load;
	logic [AW-1:0]               wb_addr_q;
	logic [fpw_pkg::ENTRY_W-1:0] wb_data_q;

	// pending result
	logic                     res_load;
	fpw_pkg::status_t         res_status_d, res_status_q;
	logic [fpw_pkg::FA_W-1:0] res_fa_d, res_fa_q;
	fpw_pkg::size_t           res_size_d, res_size_q;

	// output register
	logic                     out_load;
	logic                     out_valid_q;
	logic [1:0]               out_status_q;
	logic [fpw_pkg::FA_W-1:0] out_fa_q;
	logic [1:0]               out_size_q;

	fpw_pkg::step_t step;
	logic           root_ok;
	logic           wr_ok;

	fpw_ram #(
		.WIDTH (fpw_pkg::ENTRY_W),
		.DEPTH (fpw_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one evaluation unit, reused at every level
	fpw_step u_step (
		.entry (ram_rdata),
		.lvl   (lvl_q),
		.va    (va_q),
		.step  (step)
	);

	// frame numbers in range of the store
	assign root_ok = (32'(root_q) < 32'(fpw_pkg::TABLE_FRAMES));
	assign wr_ok   = (32'(frame_index) < 32'(fpw_pkg::TABLE_FRAMES));

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpw_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			lvl_q       <= '0;
			root_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			if (state_q == fpw_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				root_q <= root_frame;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_addr_q <= ram_raddr;
		if (req_load) begin
			req_q  <= fpw_pkg::req_t'(req_type);
			va_q   <= virt_addr;
			mask_q <= toggle_mask;
		end
		if (wb_load) begin
			wb_addr_q <= rd_addr_q;
			wb_data_q <= ram_rdata ^ fpw_pkg::flip_bits(mask_q);
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_fa_q     <= res_fa_d;
			res_size_q   <= res_size_d;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_fa_q     <= res_fa_q;
			out_size_q   <= res_size_q;
		end
	end

	// sequencer: next state and store control
	always_comb begin
		state_d      = state_q;
		lvl_d        = lvl_q;
		in_ready     = 1'b0;
		req_load     = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = clr_cnt_q;
		ram_wdata    = '0;
		ram_raddr    = rd_addr_q;
		wb_load      = 1'b0;
		res_load     = 1'b0;
		res_status_d = fpw_pkg::STS_OK;
		res_fa_d     = '0;
		res_size_d   = fpw_pkg::SIZE_4K;
		out_load     = 1'b0;
		case (state_q)
			fpw_pkg::ST_CLEAR: begin
				// zero sweep over the whole store
				ram_we = 1'b1;
				if (clr_cnt_q == AW'(fpw_pkg::STORE_DEPTH - 1)) begin
					state_d = fpw_pkg::ST_IDLE;
				end
			end
			fpw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					req_load = 1'b1;
					res_load = 1'b1;
					state_d  = fpw_pkg::ST_RESP;
					case (fpw_pkg::req_t'(req_type))
						fpw_pkg::REQ_WRITE: begin
							if (wr_ok) begin
								ram_we    = 1'b1;
								ram_waddr = {fpw_pkg::FRAME_W'(frame_index), entry_index};
								ram_wdata = entry_data;
							end else begin
								res_status_d = fpw_pkg::STS_OUT_STORE;
							end
						end
						fpw_pkg::REQ_TRANSLATE, fpw_pkg::REQ_TOGGLE: begin
							if (root_ok) begin
								// top-level read goes out on the accept edge
								res_load  = 1'b0;
								ram_raddr = {fpw_pkg::FRAME_W'(root_q),
									fpw_pkg::va_idx(virt_addr, 2'd0)};
								lvl_d     = 2'd0;
								state_d   = fpw_pkg::ST_EVAL;
							end else begin
								res_status_d = fpw_pkg::STS_OUT_STORE;
							end
						end
						default: begin
							// unused code answers all zero
							res_status_d = fpw_pkg::STS_OK;
						end
					endcase
				end
			end
			fpw_pkg::ST_EVAL: begin
				if (!step.present) begin
					res_load     = 1'b1;
					res_status_d = fpw_pkg::STS_NOT_PRESENT;
					state_d      = fpw_pkg::ST_RESP;
				end else if (step.leaf) begin
					res_load   = 1'b1;
					res_size_d = step.size;
					if (req_q == fpw_pkg::REQ_TOGGLE) begin
						wb_load = 1'b1;
						state_d = fpw_pkg::ST_WBACK;
					end else begin
						res_fa_d = step.fa;
						state_d  = fpw_pkg::ST_RESP;
					end
				end else if (!step.next_ok) begin
					res_load     = 1'b1;
					res_status_d = fpw_pkg::STS_OUT_STORE;
					state_d      = fpw_pkg::ST_RESP;
				end else begin
					// descend one level
					ram_raddr = step.next_addr;
					lvl_d     = lvl_q + 2'd1;
				end
			end
			fpw_pkg::ST_WBACK: begin
				ram_we    = 1'b1;
				ram_waddr = wb_addr_q;
				ram_wdata = wb_data_q;
				state_d   = fpw_pkg::ST_RESP;
			end
			fpw_pkg::ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = fpw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fpw_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign frame_addr = out_fa_q;
	assign page_size  = out_size_q;

	// walk never writes the store while it is reading levels
	`FPW_ASSERT_IMPLIES(a_no_write_in_walk, state_q == fpw_pkg::ST_EVAL, !ram_we, "store written during walk")
	// write-back only follows a toggle
	`FPW_ASSERT_IMPLIES(a_wback_toggle, state_q == fpw_pkg::ST_WBACK, req_q == fpw_pkg::REQ_TOGGLE, "write-back without toggle")
	// a fourth-level read always ends the walk
	`FPW_ASSERT_NEXT(a_walk_ends, (state_q == fpw_pkg::ST_EVAL) && (lvl_q == 2'd3), state_q != fpw_pkg::ST_EVAL, "walk past fourth level")
	// a result waits while the output register is still held
	`FPW_ASSERT_NEXT(a_resp_holds, (state_q == fpw_pkg::ST_RESP) && out_valid_q && !out_ready, state_q == fpw_pkg::ST_RESP, "result dropped on stall")
	// one request at a time
	`FPW_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule
